// File: sv/cts_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the chirp tone synth.
// Depends on nothing; imported by every module of the block.
package cts_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_ABITS  = $clog2(SINE_DEPTH);
    localparam int FRAC_BITS   = SINE_ABITS + 2;
    localparam int ENV_BITS    = 25;
    localparam int IDX_BITS    = 16;
    localparam int STEP_BITS   = 32;
    localparam int DEC_BITS    = 24;
    localparam int AMP_BITS    = 16;
    localparam int PCM_BITS    = 16;
    localparam int CFG_ABITS   = 3;
    localparam int CFG_DBITS   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_ABITS = $clog2(QUEUE_DEPTH);

    localparam logic [ENV_BITS-1:0]  ENV_ONE       = 25'h100_0000;
    localparam logic [15:0]          PCM_MAX       = 16'd32767;
    localparam logic [63:0]          HALF_PI_Q30   = 64'd1686629713;

    localparam logic [IDX_BITS-1:0]  RST_SAMPLE_TOTAL = 16'd4410;
    localparam logic [STEP_BITS-1:0] RST_START_INC    = 32'd204522252;
    localparam logic [DEC_BITS-1:0]  RST_INC_DEC      = 24'd33568;
    localparam logic [ENV_BITS-1:0]  RST_ENV_STEP     = 25'd3804;
    localparam logic [AMP_BITS-1:0]  RST_AMPLITUDE    = 16'd23593;

    typedef enum logic [CFG_ABITS-1:0] {
        REG_SAMPLE_TOTAL = 3'd0,
        REG_START_INC    = 3'd1,
        REG_INC_DEC      = 3'd2,
        REG_ENV_STEP     = 3'd3,
        REG_AMPLITUDE    = 3'd4
    } cts_reg_t;

    typedef struct packed {
        logic                  finished;
        logic                  last;
        logic [PHASE_BITS-1:0] phase;
        logic [ENV_BITS-1:0]   env;
    } cts_entry_t;

    typedef logic [15:0] sine_rom_t [0:SINE_DEPTH];

    // Q30 Taylor series through x^15, rounded to Q15 and capped at one
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] q;
        int          k;
        for (k = 0; k <= SINE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
            x2   = (x * x) >> 30;
            pos  = x;
            term = ((x * x2) >> 30) / 64'd6;
            neg  = term;
            term = ((term * x2) >> 30) / 64'd20;
            pos  = pos + term;
            term = ((term * x2) >> 30) / 64'd42;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 64'd72;
            pos  = pos + term;
            term = ((term * x2) >> 30) / 64'd110;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 64'd156;
            pos  = pos + term;
            term = ((term * x2) >> 30) / 64'd210;
            neg  = neg + term;
            s    = (pos > neg) ? pos - neg : 64'd0;
            q    = (s + 64'd16384) >> 15;
            if (q > 64'd32768) begin
                q = 64'd32768;
            end
            rom[k] = q[15:0];
        end
        return rom;
    endfunction

endpackage

// File: sv/chirp_tone_synth_top.sv
// Falling linear chirp synthesizer: phase accumulator DDS with squared linear envelope.
// s_ channel carries tick transactions (tdata bit 0 = restart); m_ channel carries one PCM
// sample per tick. cfg_ port writes the five chirp registers at indexes 0 to 4.
// An accepted tick enters a four-entry queue, then a four-stage multiply/round datapath.
// Throughput: one tick per cycle while the queue is not full; the front end updates all
// chirp state as each tick is accepted, and the queue decouples it from the datapath.
// When m_tready is low the datapath freezes and the queue fills; s_tready falls once the
// queue holds four ticks, and no transaction is lost or repeated.
// Reset (aresetn low, synchronous) loads the register defaults, empties queue and datapath
// and parks the chirp at sample zero with full envelope.
// A restart tick reloads start_increment and gives sample zero. After the last sample each
// tick returns silence with m_tuser high. Registers should be written only while idle.
module chirp_tone_synth_top
    import cts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,     // [0] restart, [7:1] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PCM_BITS-1:0]  m_tdata,     // [15:0] pcm_sample
    output logic                 m_tlast,
    output logic                 m_tuser,     // [0] finished
    input  logic                 cfg_wr_en,
    input  logic [CFG_ABITS-1:0] cfg_index,
    input  logic [CFG_DBITS-1:0] cfg_wdata
);

    logic [IDX_BITS-1:0]  sample_total_reg;
    logic [STEP_BITS-1:0] start_inc_reg;
    logic [DEC_BITS-1:0]  inc_dec_reg;
    logic [ENV_BITS-1:0]  env_step_reg;
    logic [AMP_BITS-1:0]  amplitude_reg;

    logic       push;
    cts_entry_t push_entry;
    logic       queue_full;
    logic       q_valid;
    logic       q_ready;
    cts_entry_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_total_reg <= RST_SAMPLE_TOTAL;
            start_inc_reg    <= RST_START_INC;
            inc_dec_reg      <= RST_INC_DEC;
            env_step_reg     <= RST_ENV_STEP;
            amplitude_reg    <= RST_AMPLITUDE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SAMPLE_TOTAL: sample_total_reg <= cfg_wdata[IDX_BITS-1:0];
                REG_START_INC:    start_inc_reg    <= cfg_wdata[STEP_BITS-1:0];
                REG_INC_DEC:      inc_dec_reg      <= cfg_wdata[DEC_BITS-1:0];
                REG_ENV_STEP:     env_step_reg     <= cfg_wdata[ENV_BITS-1:0];
                REG_AMPLITUDE:    amplitude_reg    <= cfg_wdata[AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    cts_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .restart      (s_tdata[0]),
        .sample_total (sample_total_reg),
        .start_inc    (start_inc_reg),
        .inc_dec      (inc_dec_reg),
        .env_step     (env_step_reg),
        .queue_full   (queue_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    cts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop_ready  (q_ready),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    cts_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_ready      (q_ready),
        .amplitude    (amplitude_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pcm      (m_tdata),
        .out_last     (m_tlast),
        .out_finished (m_tuser)
    );

endmodule

// File: sv/cts_front.sv
// Front end: accepts tick transactions, advances the chirp state and classifies each sample.
// Depends on cts_pkg; feeds cts_queue.
module cts_front
    import cts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    input  logic [IDX_BITS-1:0]   sample_total,
    input  logic [STEP_BITS-1:0]  start_inc,
    input  logic [DEC_BITS-1:0]   inc_dec,
    input  logic [ENV_BITS-1:0]   env_step,
    input  logic                  queue_full,
    output logic                  push,
    output cts_entry_t            push_entry
);

    logic [IDX_BITS-1:0]   idx_reg,   idx_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [STEP_BITS-1:0]  step_reg,  step_next;
    logic [ENV_BITS-1:0]   env_reg,   env_next;
    logic                  done_reg,  done_next;

    logic [IDX_BITS-1:0]   idx_e;
    logic [PHASE_BITS-1:0] phase_e;
    logic [STEP_BITS-1:0]  step_e;
    logic [ENV_BITS-1:0]   env_e;
    logic                  done_e;
    logic                  fin;
    logic                  last;
    logic [IDX_BITS:0]     idx_inc;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb begin
        idx_e   = restart ? '0 : idx_reg;
        phase_e = restart ? '0 : phase_reg;
        step_e  = restart ? start_inc : step_reg;
        env_e   = restart ? ENV_ONE : env_reg;
        done_e  = restart ? 1'b0 : done_reg;
        fin     = done_e || (idx_e >= sample_total);
        idx_inc = {1'b0, idx_e} + 17'd1;
        last    = !fin && (idx_inc == {1'b0, sample_total});

        idx_next   = idx_e;
        phase_next = phase_e;
        step_next  = step_e;
        env_next   = env_e;
        done_next  = 1'b1;
        if (!fin) begin
            idx_next   = idx_inc[IDX_BITS-1:0];
            phase_next = phase_e + step_e;
            step_next  = (step_e > STEP_BITS'(inc_dec)) ? step_e - STEP_BITS'(inc_dec) : '0;
            env_next   = (env_e > env_step) ? env_e - env_step : '0;
            done_next  = last;
        end

        push_entry.finished = fin;
        push_entry.last     = last;
        push_entry.phase    = phase_next;
        push_entry.env      = env_e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            phase_reg <= '0;
            step_reg  <= RST_START_INC;
            env_reg   <= ENV_ONE;
            done_reg  <= 1'b0;
        end else if (push) begin
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            env_reg   <= env_next;
            done_reg  <= done_next;
        end
    end

endmodule

// File: sv/cts_queue.sv
// Short FIFO between the front end and the sample datapath.
// Depends on cts_pkg for the entry type and depth.
module cts_queue
    import cts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cts_entry_t push_entry,
    output logic       full,
    input  logic       pop_ready,
    output logic       not_empty,
    output cts_entry_t head
);

    cts_entry_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_ABITS-1:0] wr_ptr_reg;
    logic [QUEUE_ABITS-1:0] rd_ptr_reg;
    logic [QUEUE_ABITS:0]   count_reg;
    logic                   pop;

    assign full      = (count_reg == (QUEUE_ABITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop       = pop_ready && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/cts_back.sv
// Sample datapath: sine lookup, envelope square, gain, rounding and output register.
// Depends on cts_pkg; drains cts_queue.
module cts_back
    import cts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  cts_entry_t           q_head,
    output logic                 q_ready,
    input  logic [AMP_BITS-1:0]  amplitude,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PCM_BITS-1:0]  out_pcm,
    output logic                 out_last,
    output logic                 out_finished
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic                  adv;
    logic [FRAC_BITS-1:0]  frac;
    logic [SINE_ABITS:0]   rom_idx;
    logic [2*ENV_BITS-1:0] env_sq;

    logic                  v1_reg, v2_reg, v3_reg, vo_reg;
    logic                  neg1_reg, neg2_reg, neg3_reg;
    logic                  fin1_reg, fin2_reg, fin3_reg;
    logic                  last1_reg, last2_reg, last3_reg;
    logic [15:0]           tv_reg;
    logic [ENV_BITS-1:0]   e2_reg;
    logic [39:0]           mag_reg;
    logic [30:0]           m_reg;
    logic [55:0]           gain_prod;
    logic [47:0]           round_prod;
    logic [16:0]           pcm_raw;
    logic [PCM_BITS-1:0]   pcm_mag;
    logic [PCM_BITS-1:0]   pcm_next;
    logic [PCM_BITS-1:0]   pcm_reg;
    logic                  last_reg;
    logic                  fin_reg;

    assign adv     = !vo_reg || out_ready;
    assign q_ready = adv;

    assign frac    = q_head.phase[PHASE_BITS-1 -: FRAC_BITS];
    assign rom_idx = frac[SINE_ABITS] ? (SINE_ABITS+1)'(SINE_DEPTH) - {1'b0, frac[SINE_ABITS-1:0]}
                                      : {1'b0, frac[SINE_ABITS-1:0]};
    assign env_sq  = q_head.env * q_head.env;

    assign gain_prod  = mag_reg * amplitude;
    assign round_prod = m_reg * 17'd32767 + 48'h2000_0000;
    assign pcm_raw    = round_prod[46:30];
    assign pcm_mag    = (pcm_raw > {1'b0, PCM_MAX}) ? PCM_MAX : pcm_raw[PCM_BITS-1:0];

    always_comb begin
        if (fin3_reg) begin
            pcm_next = '0;
        end else if (neg3_reg) begin
            pcm_next = '0 - pcm_mag;
        end else begin
            pcm_next = pcm_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tv_reg    <= SINE_ROM[rom_idx];
            e2_reg    <= env_sq[2*ENV_BITS-2:24];
            neg1_reg  <= frac[SINE_ABITS+1];
            fin1_reg  <= q_head.finished;
            last1_reg <= q_head.last;

            mag_reg   <= tv_reg * e2_reg;
            neg2_reg  <= neg1_reg;
            fin2_reg  <= fin1_reg;
            last2_reg <= last1_reg;

            m_reg     <= gain_prod[54:24];
            neg3_reg  <= neg2_reg;
            fin3_reg  <= fin2_reg;
            last3_reg <= last2_reg;

            pcm_reg   <= pcm_next;
            last_reg  <= last3_reg;
            fin_reg   <= fin3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    assign out_valid    = vo_reg;
    assign out_pcm      = pcm_reg;
    assign out_last     = last_reg;
    assign out_finished = fin_reg;

endmodule
